>>> rtl/core/wac_pkg.sv
// ----------------------------------------------------------------------------
// wac_pkg
// shared types, codes and constants of the wheel axis conditioner
// ----------------------------------------------------------------------------
package wac_pkg;

	localparam int VAL_W   = 16;
	localparam int LVL_W   = 15;
	localparam int AXIS_W  = 3;
	localparam int TRIG_W  = 4;
	localparam int DEV_W   = 4;
	localparam int FLAG_W  = 4;
	localparam int OP_W    = 2;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 15;

	localparam logic [LVL_W-1:0] FS = 15'h7fff;

	localparam int DEFAULT_WHEEL_DEV_ID = 0;
	localparam int DEFAULT_AXIS_COUNT   = 8;

	localparam int DIV_STEPS = LVL_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [OP_W-1:0] OP_AXIS  = 2'd0;
	localparam logic [OP_W-1:0] OP_CONN  = 2'd1;
	localparam logic [OP_W-1:0] OP_FRAME = 2'd2;

	localparam logic [CIDX_W-1:0] REG_STEER_AXIS    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_THROTTLE_AXIS = 3'd1;
	localparam logic [CIDX_W-1:0] REG_BRAKE_AXIS    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_TRIG_AXIS     = 3'd3;
	localparam logic [CIDX_W-1:0] REG_STEER_DZ      = 3'd4;
	localparam logic [CIDX_W-1:0] REG_PEDAL_DZ      = 3'd5;
	localparam logic [CIDX_W-1:0] REG_TRIGGER_DZ    = 3'd6;
	localparam logic [CIDX_W-1:0] REG_INVERT        = 3'd7;

	localparam int INV_STEER    = 0;
	localparam int INV_THROTTLE = 1;
	localparam int INV_BRAKE    = 2;
	localparam int INV_TRIGGER  = 3;

	localparam logic [AXIS_W-1:0] RST_STEER_AXIS    = 3'd0;
	localparam logic [AXIS_W-1:0] RST_THROTTLE_AXIS = 3'd2;
	localparam logic [AXIS_W-1:0] RST_BRAKE_AXIS    = 3'd3;
	localparam logic [TRIG_W-1:0] RST_TRIG_AXIS     = 4'hf;
	localparam logic [LVL_W-1:0]  RST_STEER_DZ      = 15'd1311;
	localparam logic [LVL_W-1:0]  RST_PEDAL_DZ      = 15'd3277;
	localparam logic [LVL_W-1:0]  RST_TRIGGER_DZ    = 15'd1966;
	localparam logic [FLAG_W-1:0] RST_INVERT        = 4'h0;

	typedef struct packed {
		logic [AXIS_W-1:0] steer_axis;
		logic [AXIS_W-1:0] throttle_axis;
		logic [AXIS_W-1:0] brake_axis;
		logic [TRIG_W-1:0] trig_axis;
		logic [LVL_W-1:0]  steer_deadzone;
		logic [LVL_W-1:0]  pedal_deadzone;
		logic [LVL_W-1:0]  trigger_deadzone;
		logic [FLAG_W-1:0] invert_flags;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] num;
		logic [LVL_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [LVL_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> rtl/core/wac_if.sv
// ----------------------------------------------------------------------------
// wac_if
// event and drive channels of the wheel axis conditioner
// ----------------------------------------------------------------------------
interface wac_evt_if;
	logic                               valid;
	logic                               ready;
	logic [wac_pkg::OP_W-1:0]           op;
	logic [wac_pkg::AXIS_W-1:0]         axis_index;
	logic signed [wac_pkg::VAL_W-1:0]   axis_value;
	logic [wac_pkg::DEV_W-1:0]          device_id;
	logic                               connected;
	logic                               vehicle_alive;

	modport source (output valid, op, axis_index, axis_value, device_id, connected,
		vehicle_alive, input ready);
	modport sink (input valid, op, axis_index, axis_value, device_id, connected,
		vehicle_alive, output ready);
endinterface

interface wac_drive_if;
	logic                             valid;
	logic                             ready;
	logic                             apply;
	logic signed [wac_pkg::VAL_W-1:0] steer_out;
	logic signed [wac_pkg::VAL_W-1:0] throttle_out;

	modport source (output valid, apply, steer_out, throttle_out, input ready);
	modport sink (input valid, apply, steer_out, throttle_out, output ready);
endinterface

>>> rtl/core/wac_cfg.sv
// ----------------------------------------------------------------------------
// wac_cfg
// configuration register file, written by index
// ----------------------------------------------------------------------------
module wac_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [wac_pkg::CIDX_W-1:0]     index,
	input  logic [wac_pkg::CDATA_W-1:0]    data,
	output wac_pkg::cfg_t                  cfg
);

	wac_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steer_axis       <= wac_pkg::RST_STEER_AXIS;
			cfg_q.throttle_axis    <= wac_pkg::RST_THROTTLE_AXIS;
			cfg_q.brake_axis       <= wac_pkg::RST_BRAKE_AXIS;
			cfg_q.trig_axis        <= wac_pkg::RST_TRIG_AXIS;
			cfg_q.steer_deadzone   <= wac_pkg::RST_STEER_DZ;
			cfg_q.pedal_deadzone   <= wac_pkg::RST_PEDAL_DZ;
			cfg_q.trigger_deadzone <= wac_pkg::RST_TRIGGER_DZ;
			cfg_q.invert_flags     <= wac_pkg::RST_INVERT;
		end else if (we) begin
			case (index)
				wac_pkg::REG_STEER_AXIS:    cfg_q.steer_axis    <= data[wac_pkg::AXIS_W-1:0];
				wac_pkg::REG_THROTTLE_AXIS: cfg_q.throttle_axis <= data[wac_pkg::AXIS_W-1:0];
				wac_pkg::REG_BRAKE_AXIS:    cfg_q.brake_axis    <= data[wac_pkg::AXIS_W-1:0];
				wac_pkg::REG_TRIG_AXIS:     cfg_q.trig_axis     <= data[wac_pkg::TRIG_W-1:0];
				wac_pkg::REG_STEER_DZ:      cfg_q.steer_deadzone   <= data[wac_pkg::LVL_W-1:0];
				wac_pkg::REG_PEDAL_DZ:      cfg_q.pedal_deadzone   <= data[wac_pkg::LVL_W-1:0];
				wac_pkg::REG_TRIGGER_DZ:    cfg_q.trigger_deadzone <= data[wac_pkg::LVL_W-1:0];
				wac_pkg::REG_INVERT:        cfg_q.invert_flags  <= data[wac_pkg::FLAG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/wac_div.sv
// ----------------------------------------------------------------------------
// wac_div
// shared rescale unit: min(num * FS / den, FS), one quotient bit per cycle
// ----------------------------------------------------------------------------
module wac_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wac_pkg::div_req_t req,
	output wac_pkg::div_rsp_t rsp
);

	localparam int QW = wac_pkg::LVL_W;

	logic                          busy_q;
	logic                          done_q;
	logic [wac_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [QW-1:0]                 rem_q;
	logic [QW-1:0]                 low_q;
	logic [QW-1:0]                 quot_q;
	logic [QW-1:0]                 den_q;

	logic                          sat;
	logic [2*QW-1:0]               dvd;
	logic [QW:0]                   trial;
	logic                          ge;
	logic [QW-1:0]                 diff;

	// num * FS as (num << 15) - num
	assign sat   = req.num > {1'b0, req.den};
	assign dvd   = {req.num[QW-1:0], {QW{1'b0}}} - {{QW{1'b0}}, req.num[QW-1:0]};
	assign trial = {rem_q, low_q[QW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial[QW-1:0] - den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wac_pkg::DIV_CNT_W'(wac_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= dvd[2*QW-1:QW];
			low_q <= dvd[QW-1:0];
			if (sat) begin
				quot_q <= wac_pkg::FS;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? diff : trial[QW-1:0];
			low_q  <= {low_q[QW-2:0], 1'b0};
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

>>> rtl/core/wheel_axis_conditioner_core.sv
// ----------------------------------------------------------------------------
// wheel_axis_conditioner_core
// routes axis samples into steer and pedal state, reports conditioned drive
// ----------------------------------------------------------------------------
// an event passes from IDLE through PREP, and through DIV when a rescale runs on the shared
// divider (15 quotient bits, one per cycle); a frame tick passes through DONE as well
// a frame tick's drive result is registered as the sequencer leaves DONE
// ready only while the sequencer is idle; a tick waits while the last result is held
// arst_n clears config to defaults, state to not present, centered, zero levels
module wheel_axis_conditioner_core #(
	parameter int WHEEL_DEV_ID = wac_pkg::DEFAULT_WHEEL_DEV_ID,
	parameter int AXIS_COUNT   = wac_pkg::DEFAULT_AXIS_COUNT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wac_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [wac_pkg::CDATA_W-1:0] cfg_data,
	wac_evt_if.sink                     evt,
	wac_drive_if.source                 drive
);

	localparam int VW = wac_pkg::VAL_W;
	localparam int LW = wac_pkg::LVL_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		TGT_GAS,
		TGT_BRAKE,
		TGT_STEER
	} tgt_t;

	wac_pkg::cfg_t     cfg;
	wac_pkg::div_req_t div_req;
	wac_pkg::div_rsp_t div_rsp;

	state_t state_q;
	tgt_t   tgt_q;

	logic [wac_pkg::OP_W-1:0]   op_q;
	logic [wac_pkg::AXIS_W-1:0] idx_q;
	logic signed [VW-1:0]       val_q;
	logic [wac_pkg::DEV_W-1:0]  dev_q;
	logic                       conn_q;
	logic                       alive_q;

	logic                       present_q;
	logic signed [VW-1:0]       steer_raw_q;
	logic [LW-1:0]              gas_q;
	logic [LW-1:0]              brake_q;

	logic                       go_q;
	logic                       sneg_q;
	logic signed [VW-1:0]       st_q;

	logic                       out_valid_q;
	logic                       out_apply_q;
	logic signed [VW-1:0]       out_steer_q;
	logic signed [VW-1:0]       out_thr_q;

	logic                       evt_xfer;
	logic                       out_free;
	logic                       idx_ok;
	logic                       go;
	logic signed [VW:0]         v17;
	logic signed [VW:0]         t17;
	logic signed [VW:0]         s17;
	logic signed [VW:0]         mag;
	logic [LW-1:0]              dz;
	logic [LW-1:0]              pedal_p;
	logic                       prep_div;
	tgt_t                       prep_tgt;
	logic                       steer_wr;
	logic                       gas_clr;
	logic                       brake_clr;
	logic [VW-1:0]              num_dz;
	logic signed [VW-1:0]       thr;

	wac_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	wac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign evt_xfer  = evt.valid && evt.ready;
	assign evt.ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || drive.ready;

	assign idx_ok = int'(idx_q) < AXIS_COUNT;
	assign go     = present_q && alive_q;
	assign v17    = {val_q[VW-1], val_q};
	assign t17    = cfg.invert_flags[wac_pkg::INV_TRIGGER] ? -v17 : v17;
	assign s17    = {steer_raw_q[VW-1], steer_raw_q};

	always_comb begin
		prep_div  = 1'b0;
		prep_tgt  = TGT_STEER;
		steer_wr  = 1'b0;
		gas_clr   = 1'b0;
		brake_clr = 1'b0;
		mag       = '0;
		dz        = cfg.steer_deadzone;
		pedal_p   = {~val_q[VW-1], val_q[VW-2:1]};
		case (op_q)
			wac_pkg::OP_AXIS: begin
				if (idx_ok) begin
					steer_wr = (idx_q == cfg.steer_axis);
					if (!cfg.trig_axis[wac_pkg::TRIG_W-1]) begin
						if (idx_q == cfg.trig_axis[wac_pkg::AXIS_W-1:0]) begin
							dz = cfg.trigger_deadzone;
							if (t17 > $signed({2'b00, dz})) begin
								prep_div  = 1'b1;
								prep_tgt  = TGT_GAS;
								mag       = t17;
								brake_clr = 1'b1;
							end else if (t17 < -$signed({2'b00, dz})) begin
								prep_div = 1'b1;
								prep_tgt = TGT_BRAKE;
								mag      = -t17;
								gas_clr  = 1'b1;
							end else begin
								gas_clr   = 1'b1;
								brake_clr = 1'b1;
							end
						end
					end else if (idx_q == cfg.throttle_axis) begin
						dz = cfg.pedal_deadzone;
						if (cfg.invert_flags[wac_pkg::INV_THROTTLE]) begin
							pedal_p = ~pedal_p;
						end
						prep_tgt = TGT_GAS;
						mag      = {2'b00, pedal_p};
						prep_div = pedal_p > dz;
						gas_clr  = !prep_div;
					end else if (idx_q == cfg.brake_axis) begin
						dz = cfg.pedal_deadzone;
						if (cfg.invert_flags[wac_pkg::INV_BRAKE]) begin
							pedal_p = ~pedal_p;
						end
						prep_tgt  = TGT_BRAKE;
						mag       = {2'b00, pedal_p};
						prep_div  = pedal_p > dz;
						brake_clr = !prep_div;
					end
				end
			end
			wac_pkg::OP_FRAME: begin
				mag      = s17[VW] ? -s17 : s17;
				prep_tgt = TGT_STEER;
				prep_div = go && (mag > $signed({2'b00, dz}));
			end
			default: ;
		endcase
	end

	assign num_dz        = VW'(mag - $signed({2'b00, dz}));
	assign div_req.start = (state_q == ST_PREP) && prep_div;
	assign div_req.num   = num_dz;
	assign div_req.den   = ~dz;

	assign thr = VW'({1'b0, gas_q}) - VW'({1'b0, brake_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			present_q   <= 1'b0;
			steer_raw_q <= '0;
			gas_q       <= '0;
			brake_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (drive.valid && drive.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (evt_xfer) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					case (op_q)
						wac_pkg::OP_AXIS: begin
							if (steer_wr) begin
								steer_raw_q <= val_q;
							end
							if (gas_clr) begin
								gas_q <= '0;
							end
							if (brake_clr) begin
								brake_q <= '0;
							end
							state_q <= prep_div ? ST_DIV : ST_IDLE;
						end
						wac_pkg::OP_CONN: begin
							if (dev_q == wac_pkg::DEV_W'(WHEEL_DEV_ID)) begin
								present_q <= conn_q;
							end
							state_q <= ST_IDLE;
						end
						wac_pkg::OP_FRAME: begin
							state_q <= prep_div ? ST_DIV : ST_DONE;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						case (tgt_q)
							TGT_GAS: begin
								gas_q   <= div_rsp.quot;
								state_q <= ST_IDLE;
							end
							TGT_BRAKE: begin
								brake_q <= div_rsp.quot;
								state_q <= ST_IDLE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (evt_xfer) begin
			op_q    <= evt.op;
			idx_q   <= evt.axis_index;
			val_q   <= evt.axis_value;
			dev_q   <= evt.device_id;
			conn_q  <= evt.connected;
			alive_q <= evt.vehicle_alive;
		end
		if (state_q == ST_PREP) begin
			tgt_q  <= prep_tgt;
			go_q   <= go;
			sneg_q <= steer_raw_q[VW-1] ^ cfg.invert_flags[wac_pkg::INV_STEER];
			st_q   <= '0;
		end
		if (state_q == ST_DIV && div_rsp.done && tgt_q == TGT_STEER) begin
			st_q <= sneg_q ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
		end
		if (state_q == ST_DONE && out_free) begin
			out_apply_q <= go_q;
			out_steer_q <= go_q ? st_q : '0;
			out_thr_q   <= go_q ? thr : '0;
		end
	end

	assign drive.valid        = out_valid_q;
	assign drive.apply        = out_apply_q;
	assign drive.steer_out    = out_steer_q;
	assign drive.throttle_out = out_thr_q;

endmodule

>>> rtl/core/wac_checker.sv
// ----------------------------------------------------------------------------
// wac_checker
// port level checks of the wheel axis conditioner, bound to the top level
// ----------------------------------------------------------------------------
module wac_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        evt_valid,
	input logic                        evt_ready,
	input logic                        drv_valid,
	input logic                        drv_ready,
	input logic                        apply,
	input logic signed [wac_pkg::VAL_W-1:0] steer_out,
	input logic signed [wac_pkg::VAL_W-1:0] throttle_out
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		drv_valid && !drv_ready |=> drv_valid && $stable(apply) && $stable(steer_out)
			&& $stable(throttle_out))
	else $error("drive result changed while stalled");

	// each event transfer keeps the sequencer busy for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> !evt_ready)
	else $error("event taken while previous one still in work");

	// no override means neutral outputs
	assert property (@(posedge clk) disable iff (!arst_n)
		drv_valid && !apply |-> steer_out == '0 && throttle_out == '0)
	else $error("nonzero drive without apply");

	// outputs stay inside the symmetric range
	assert property (@(posedge clk) disable iff (!arst_n)
		drv_valid |-> steer_out != 16'sh8000 && throttle_out != 16'sh8000)
	else $error("drive output at negative full scale");

endmodule

bind wheel_axis_conditioner_core wac_checker u_wac_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.evt_valid    (evt.valid),
	.evt_ready    (evt.ready),
	.drv_valid    (drive.valid),
	.drv_ready    (drive.ready),
	.apply        (drive.apply),
	.steer_out    (drive.steer_out),
	.throttle_out (drive.throttle_out)
);

>>> tb/wheel_axis_conditioner_core_tb.sv
// ----------------------------------------------------------------------------
// wheel_axis_conditioner_core_tb
// self-checking bench for the wheel axis conditioner core
// ----------------------------------------------------------------------------
// Controller events go in on the event channel and drive results come out on
// the drive channel, with idle gaps on events and stalls on results. A
// cycle-free predictor tracks presence, raw steer and the pedal levels. It
// turns every frame tick into an expected drive result, and results are
// checked in order.
// Runs start with directed presence events and events at the value extremes.
// Random traffic then follows under several register settings: separate and
// split-trigger pedals, zero and full-scale deadzones, and every inversion flag.
// ----------------------------------------------------------------------------
module wheel_axis_conditioner_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int OW = wac_pkg::OP_W;
	localparam int AW = wac_pkg::AXIS_W;
	localparam int VW = wac_pkg::VAL_W;
	localparam int DW = wac_pkg::DEV_W;
	localparam int LW = wac_pkg::LVL_W;
	localparam int TW = wac_pkg::TRIG_W;
	localparam int FW = wac_pkg::FLAG_W;
	localparam int IW = wac_pkg::CIDX_W;
	localparam int CW = wac_pkg::CDATA_W;

	localparam logic [OW-1:0] OP_UNUSED = 2'd3;
	localparam logic [DW-1:0] WHEEL_ID  = DW'(wac_pkg::DEFAULT_WHEEL_DEV_ID);
	localparam int AXIS_LIMIT    = wac_pkg::DEFAULT_AXIS_COUNT;
	localparam int FULL_SCALE    = wac_pkg::FS;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 2000;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		logic [OW-1:0]         op;
		logic [AW-1:0]         axis_index;
		logic signed [VW-1:0]  axis_value;
		logic [DW-1:0]         device_id;
		logic                  connected;
		logic                  vehicle_alive;
	} wheel_event_t;

	typedef struct {
		logic                 apply;
		logic signed [VW-1:0] steer;
		logic signed [VW-1:0] throttle;
	} drive_cmd_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [IW-1:0]   cfg_index;
	logic [CW-1:0]   cfg_data;

	wac_evt_if   evt ();
	wac_drive_if drive ();

	wheel_axis_conditioner_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.evt       (evt),
		.drive     (drive)
	);

	// shadow of the block's registers and state
	wac_pkg::cfg_t shadow_cfg;
	bit   wheel_present;
	int   steer_raw;
	int   gas_level;
	int   brake_level;

	drive_cmd_t drive_expect_q[$];

	bit steady;
	int n_events;
	int n_checked;
	int n_settings;
	int n_errors;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	function automatic int rescale_level(int mag, int dz);
		longint q;
		if (FULL_SCALE - dz <= 0)
			return FULL_SCALE;
		q = (longint'(mag - dz) * FULL_SCALE) / (FULL_SCALE - dz);
		return (q > FULL_SCALE) ? FULL_SCALE : int'(q);
	endfunction

	function automatic int pedal_level(int v, bit inv);
		int p;
		int dz;
		p = (v + 32768) >>> 1;
		dz = int'(shadow_cfg.pedal_deadzone);
		if (inv)
			p = FULL_SCALE - p;
		if (p <= dz)
			return 0;
		return rescale_level(p, dz);
	endfunction

	function automatic void track_axis(int a, int v);
		int t;
		int dz;
		if (a >= AXIS_LIMIT)
			return;
		if (a == int'(shadow_cfg.steer_axis))
			steer_raw = v;
		// negative trigger index selects separate pedals
		if (!shadow_cfg.trig_axis[TW-1]) begin
			if (a == int'(shadow_cfg.trig_axis)) begin
				t = shadow_cfg.invert_flags[wac_pkg::INV_TRIGGER] ? -v : v;
				dz = int'(shadow_cfg.trigger_deadzone);
				if (t > dz) begin
					gas_level = rescale_level(t, dz);
					brake_level = 0;
				end else if (t < -dz) begin
					brake_level = rescale_level(-t, dz);
					gas_level = 0;
				end else begin
					gas_level = 0;
					brake_level = 0;
				end
			end
		end else if (a == int'(shadow_cfg.throttle_axis)) begin
			gas_level = pedal_level(v, shadow_cfg.invert_flags[wac_pkg::INV_THROTTLE]);
		end else if (a == int'(shadow_cfg.brake_axis)) begin
			brake_level = pedal_level(v, shadow_cfg.invert_flags[wac_pkg::INV_BRAKE]);
		end
	endfunction

	function automatic int steer_cmd();
		int mag;
		int dz;
		int r;
		dz = int'(shadow_cfg.steer_deadzone);
		mag = (steer_raw < 0) ? -steer_raw : steer_raw;
		if (mag <= dz)
			return 0;
		r = rescale_level(mag, dz);
		if (steer_raw < 0)
			r = -r;
		if (shadow_cfg.invert_flags[wac_pkg::INV_STEER])
			r = -r;
		return r;
	endfunction

	function automatic void predict_event(wheel_event_t e);
		drive_cmd_t d;
		int st;
		int th;
		case (e.op)
			wac_pkg::OP_AXIS: track_axis(int'(e.axis_index), int'(e.axis_value));
			wac_pkg::OP_CONN: begin
				if (e.device_id == WHEEL_ID)
					wheel_present = e.connected;
			end
			wac_pkg::OP_FRAME: begin
				st = 0;
				th = 0;
				d.apply = wheel_present && e.vehicle_alive;
				if (d.apply) begin
					st = steer_cmd();
					th = gas_level - brake_level;
					if (th > FULL_SCALE)
						th = FULL_SCALE;
					if (th < -FULL_SCALE)
						th = -FULL_SCALE;
				end
				d.steer = st[VW-1:0];
				d.throttle = th[VW-1:0];
				drive_expect_q.push_back(d);
			end
			default: ;
		endcase
	endfunction

	function automatic void note_error(string msg);
		n_errors++;
		if (n_errors <= REPORT_MAX)
			$display("%t mismatch: %s", $realtime, msg);
	endfunction

	function automatic void check_drive(drive_cmd_t got);
		drive_cmd_t want;
		if (drive_expect_q.size() == 0) begin
			note_error($sformatf("unexpected drive apply=%0b steer=%0d throttle=%0d",
				got.apply, got.steer, got.throttle));
			return;
		end
		want = drive_expect_q.pop_front();
		n_checked++;
		if (got.apply !== want.apply || got.steer !== want.steer
				|| got.throttle !== want.throttle)
			note_error($sformatf(
				"drive expected apply=%0b steer=%0d throttle=%0d, got %0b %0d %0d",
				want.apply, want.steer, want.throttle,
				got.apply, got.steer, got.throttle));
	endfunction

	function automatic wheel_event_t make_event(logic [OW-1:0] op);
		wheel_event_t e;
		e.op = op;
		e.axis_index = AW'($urandom_range(7));
		e.axis_value = VW'($urandom);
		e.device_id = DW'($urandom_range(15));
		e.connected = 1'($urandom_range(1));
		e.vehicle_alive = 1'($urandom_range(1));
		return e;
	endfunction

	function automatic logic signed [VW-1:0] axis_sample();
		int corners[6] = '{-32768, -32767, -1, 0, 1, 32767};
		int v;
		int d;
		int sdz;
		int tdz;
		int pdz;
		sdz = int'(shadow_cfg.steer_deadzone);
		tdz = int'(shadow_cfg.trigger_deadzone);
		pdz = int'(shadow_cfg.pedal_deadzone);
		d = int'($urandom_range(4)) - 2;
		case ($urandom_range(9))
			0: v = corners[$urandom_range(5)];
			1: v = sdz + d;
			2: v = -sdz - d;
			3: v = tdz + d;
			4: v = -tdz - d;
			5: v = 2 * pdz - 32768 + d;
			6: v = 32766 - 2 * pdz + d;
			default: v = int'($urandom_range(65535)) - 32768;
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[VW-1:0];
	endfunction

	// mostly samples on routed axes, with presence changes and frame ticks
	function automatic wheel_event_t random_event();
		wheel_event_t e;
		int r;
		r = $urandom_range(99);
		if (r < 2) begin
			e = make_event(OP_UNUSED);
		end else if (r < 9) begin
			e = make_event(wac_pkg::OP_CONN);
			if ($urandom_range(3) != 0)
				e.device_id = WHEEL_ID;
			e.connected = ($urandom_range(4) != 0);
		end else if (r < 40) begin
			e = make_event(wac_pkg::OP_FRAME);
			e.vehicle_alive = ($urandom_range(7) != 0);
		end else begin
			e = make_event(wac_pkg::OP_AXIS);
			case ($urandom_range(4))
				0: e.axis_index = shadow_cfg.steer_axis;
				1: e.axis_index = shadow_cfg.throttle_axis;
				2: e.axis_index = shadow_cfg.brake_axis;
				3: e.axis_index = shadow_cfg.trig_axis[AW-1:0];
				default: ;
			endcase
			e.axis_value = axis_sample();
		end
		return e;
	endfunction

	function automatic logic [LW-1:0] random_deadzone();
		case ($urandom_range(9))
			0, 1: return '0;
			2: return wac_pkg::FS;
			3: return wac_pkg::FS - 15'd1;
			4, 5: return LW'($urandom_range(32767));
			default: return LW'($urandom_range(8000));
		endcase
	endfunction

	function automatic wac_pkg::cfg_t random_settings();
		wac_pkg::cfg_t s;
		s.steer_axis = AW'($urandom_range(7));
		s.throttle_axis = AW'($urandom_range(7));
		s.brake_axis = AW'($urandom_range(7));
		s.trig_axis = TW'($urandom_range(15));
		s.steer_deadzone = random_deadzone();
		s.pedal_deadzone = random_deadzone();
		s.trigger_deadzone = random_deadzone();
		s.invert_flags = FW'($urandom_range(15));
		return s;
	endfunction

	task automatic send_event(wheel_event_t e);
		int gap;
		evt.valid <= 1'b1;
		evt.op <= e.op;
		evt.axis_index <= e.axis_index;
		evt.axis_value <= e.axis_value;
		evt.device_id <= e.device_id;
		evt.connected <= e.connected;
		evt.vehicle_alive <= e.vehicle_alive;
		@(posedge clk);
		while (evt.ready !== 1'b1)
			@(posedge clk);
		predict_event(e);
		n_events++;
		gap = pick_gap();
		if (gap > 0) begin
			evt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_axis(logic [AW-1:0] idx, int value);
		wheel_event_t e;
		e = make_event(wac_pkg::OP_AXIS);
		e.axis_index = idx;
		e.axis_value = value[VW-1:0];
		send_event(e);
	endtask

	task automatic send_conn(logic [DW-1:0] dev, logic conn);
		wheel_event_t e;
		e = make_event(wac_pkg::OP_CONN);
		e.device_id = dev;
		e.connected = conn;
		send_event(e);
	endtask

	task automatic send_frame(logic alive);
		wheel_event_t e;
		e = make_event(wac_pkg::OP_FRAME);
		e.vehicle_alive = alive;
		send_event(e);
	endtask

	// hold the sender until every drive result is back and the block is idle
	task automatic drain_pipeline();
		if (evt.valid)
			evt.valid <= 1'b0;
		while (drive_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(wac_pkg::cfg_t s);
		logic [IW-1:0] idx;
		logic [CW-1:0] data;
		drain_pipeline();
		for (int i = 0; i < 2 ** IW; i++) begin
			idx = IW'(i);
			case (idx)
				wac_pkg::REG_STEER_AXIS:    data = CW'(s.steer_axis);
				wac_pkg::REG_THROTTLE_AXIS: data = CW'(s.throttle_axis);
				wac_pkg::REG_BRAKE_AXIS:    data = CW'(s.brake_axis);
				wac_pkg::REG_TRIG_AXIS:     data = CW'(s.trig_axis);
				wac_pkg::REG_STEER_DZ:      data = s.steer_deadzone;
				wac_pkg::REG_PEDAL_DZ:      data = s.pedal_deadzone;
				wac_pkg::REG_TRIGGER_DZ:    data = s.trigger_deadzone;
				wac_pkg::REG_INVERT:        data = CW'(s.invert_flags);
				default:                    data = '0;
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		shadow_cfg = s;
		n_settings++;
	endtask

	task automatic run_random(int count);
		repeat (count) send_event(random_event());
	endtask

	task automatic test_presence();
		wheel_event_t e;
		send_frame(1'b1);
		send_conn(4'd5, 1'b1);
		send_frame(1'b1);
		send_conn(WHEEL_ID, 1'b1);
		send_frame(1'b0);
		send_frame(1'b1);
		e = make_event(OP_UNUSED);
		send_event(e);
		send_frame(1'b1);
		send_conn(WHEEL_ID, 1'b0);
		send_frame(1'b1);
		send_conn(WHEEL_ID, 1'b1);
	endtask

	task automatic test_axis_extremes();
		send_axis(wac_pkg::RST_STEER_AXIS, -32768);
		send_frame(1'b1);
		send_axis(wac_pkg::RST_STEER_AXIS, 32767);
		send_axis(wac_pkg::RST_THROTTLE_AXIS, 32767);
		send_axis(wac_pkg::RST_BRAKE_AXIS, -32768);
		send_frame(1'b1);
		send_axis(wac_pkg::RST_BRAKE_AXIS, 32767);
		send_frame(1'b1);
		send_axis(wac_pkg::RST_THROTTLE_AXIS, -32768);
		send_axis(wac_pkg::RST_STEER_AXIS, int'(wac_pkg::RST_STEER_DZ));
		send_axis(3'd7, 12345);
		send_frame(1'b1);
	endtask

	task automatic test_default_random();
		steady = 1'b1;
		run_random(100);
		steady = 1'b0;
		run_random(150);
	endtask

	task automatic test_separate_pedals_inverted();
		wac_pkg::cfg_t s;
		s = '{steer_axis: 3'd1, throttle_axis: 3'd4, brake_axis: 3'd5,
			trig_axis: 4'hf, steer_deadzone: '0, pedal_deadzone: '0,
			trigger_deadzone: '0, invert_flags: 4'hf};
		load_settings(s);
		send_conn(WHEEL_ID, 1'b1);
		run_random(250);
	endtask

	task automatic test_full_scale_deadzones();
		wac_pkg::cfg_t s;
		s = '{steer_axis: 3'd7, throttle_axis: 3'd0, brake_axis: 3'd0,
			trig_axis: 4'd6, steer_deadzone: wac_pkg::FS, pedal_deadzone: wac_pkg::FS,
			trigger_deadzone: wac_pkg::FS, invert_flags: 4'h8};
		load_settings(s);
		send_conn(WHEEL_ID, 1'b1);
		run_random(250);
	endtask

	task automatic test_split_trigger();
		wac_pkg::cfg_t s;
		s = random_settings();
		s.steer_axis = 3'd0;
		s.trig_axis = 4'd0;
		s.trigger_deadzone = LW'($urandom_range(6000));
		s.steer_deadzone = LW'($urandom_range(6000));
		load_settings(s);
		send_conn(WHEEL_ID, 1'b1);
		run_random(250);
	endtask

	task automatic test_random_settings();
		repeat (4) begin
			load_settings(random_settings());
			send_conn(WHEEL_ID, 1'b1);
			run_random(140);
		end
	endtask

	initial begin : drive_sink
		int stall;
		drive_cmd_t got;
		stall = 0;
		drive.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (drive.valid === 1'b1 && drive.ready === 1'b1) begin
				got.apply = drive.apply;
				got.steer = drive.steer_out;
				got.throttle = drive.throttle_out;
				check_drive(got);
			end
			if (stall > 0) begin
				stall--;
				drive.ready <= 1'b0;
			end else begin
				drive.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((evt.valid === 1'b1 && evt.ready === 1'b1)
					|| (drive.valid === 1'b1 && drive.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%t timeout: no transfer for %0d cycles", $realtime, STALL_LIMIT);
		$display("[wheel_axis_conditioner_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		evt.valid <= 1'b0;
		evt.op <= wac_pkg::OP_AXIS;
		evt.axis_index <= '0;
		evt.axis_value <= '0;
		evt.device_id <= '0;
		evt.connected <= 1'b0;
		evt.vehicle_alive <= 1'b0;
		shadow_cfg = '{steer_axis: wac_pkg::RST_STEER_AXIS,
			throttle_axis: wac_pkg::RST_THROTTLE_AXIS,
			brake_axis: wac_pkg::RST_BRAKE_AXIS, trig_axis: wac_pkg::RST_TRIG_AXIS,
			steer_deadzone: wac_pkg::RST_STEER_DZ, pedal_deadzone: wac_pkg::RST_PEDAL_DZ,
			trigger_deadzone: wac_pkg::RST_TRIGGER_DZ, invert_flags: wac_pkg::RST_INVERT};
		wheel_present = 1'b0;
		steer_raw = 0;
		gas_level = 0;
		brake_level = 0;
		steady = 1'b0;
		n_events = 0;
		n_checked = 0;
		n_settings = 1;
		n_errors = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_presence();
		test_axis_extremes();
		test_default_random();
		test_separate_pedals_inverted();
		test_full_scale_deadzones();
		test_split_trigger();
		test_random_settings();
		drain_pipeline();
		if (drive_expect_q.size() != 0)
			note_error($sformatf("%0d drive results never arrived", drive_expect_q.size()));
		$display("%0d events over %0d register settings, %0d drive results checked",
			n_events, n_settings, n_checked);
		$display("covered split trigger, separate pedals, zero and full-scale deadzones,"
			, " all inversion flags, %0d mismatches", n_errors);
		if (n_errors == 0)
			$display("[wheel_axis_conditioner_core] OK");
		else
			$display("[wheel_axis_conditioner_core] ERROR");
		$finish;
	end

endmodule
